@@ rtl/fpm_pkg.sv @@
package fpm_pkg;

  localparam int VTX_W  = 24;
  localparam int CELL_W = 24;
  localparam int CNT_W  = 26;
  localparam int SLOT_W = 27;

  typedef enum logic [1:0] {
    ST_MATCH  = 2'd0,
    ST_INSERT = 2'd1,
    ST_FULL   = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SH_BTRI, SH_BQUAD, SH_TET, SH_PYR, SH_PRISM, SH_HEX, SH_BAD
  } shape_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_id;
    logic              boundary;
    logic [3:0]        vertex_count;
    logic [VTX_W-1:0]  vertex_0;
    logic [VTX_W-1:0]  vertex_1;
    logic [VTX_W-1:0]  vertex_2;
    logic [VTX_W-1:0]  vertex_3;
    logic [VTX_W-1:0]  vertex_4;
    logic [VTX_W-1:0]  vertex_5;
    logic [VTX_W-1:0]  vertex_6;
    logic [VTX_W-1:0]  vertex_7;
  } cell_in_t;

  typedef struct packed {
    status_t           status;
    logic              is_quad;
    logic [SLOT_W-1:0] face_slot;
    logic [CELL_W-1:0] cell_new;
    logic [CELL_W-1:0] cell_old;
    logic              last;
  } face_out_t;

  // one face of the current cell, key sorted ascending
  typedef struct packed {
    logic                       bad;
    logic                       is_quad;
    logic                       last;
    logic [3:0][VTX_W-1:0]      key;
  } face_t;

  typedef struct packed {
    logic                       is_quad;
    logic [CELL_W-1:0]          cell_id;
    logic [3:0][VTX_W-1:0]      key;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [CELL_W-1:0] cell_old;
  } res_t;

  typedef struct packed {
    logic req_valid;
    logic res_take;
  } probe_ctl_t;

  typedef struct packed {
    logic clearing;
    logic req_take;
    logic res_valid;
  } probe_stat_t;

  // table entry state codes
  localparam logic [1:0] E_EMPTY = 2'd0;
  localparam logic [1:0] E_USED  = 2'd1;
  localparam logic [1:0] E_TOMB  = 2'd2;

  typedef struct packed {
    logic       quad;
    logic [2:0] i0;
    logic [2:0] i1;
    logic [2:0] i2;
    logic [2:0] i3;
  } pick_t;

  function automatic logic [2:0] face_count(shape_t sh);
    case (sh)
      SH_TET:   face_count = 3'd4;
      SH_PYR:   face_count = 3'd5;
      SH_PRISM: face_count = 3'd5;
      SH_HEX:   face_count = 3'd6;
      default:  face_count = 3'd1;
    endcase
  endfunction

  function automatic pick_t mk(logic q, int a, int b, int c, int d);
    pick_t p;
    p.quad = q;
    p.i0 = 3'(a);
    p.i1 = 3'(b);
    p.i2 = 3'(c);
    p.i3 = 3'(d);
    return p;
  endfunction

  function automatic pick_t face_pick(shape_t sh, logic [2:0] k);
    pick_t p;
    p = mk(1'b0, 0, 1, 2, 0);
    case (sh)
      SH_BQUAD: p = mk(1'b1, 0, 1, 2, 3);
      SH_TET: begin
        case (k)
          3'd1:    p = mk(1'b0, 1, 2, 3, 0);
          3'd2:    p = mk(1'b0, 2, 3, 0, 0);
          3'd3:    p = mk(1'b0, 3, 0, 1, 0);
          default: p = mk(1'b0, 0, 1, 2, 0);
        endcase
      end
      SH_PYR: begin
        case (k)
          3'd1:    p = mk(1'b0, 0, 1, 4, 0);
          3'd2:    p = mk(1'b0, 1, 2, 4, 0);
          3'd3:    p = mk(1'b0, 2, 3, 4, 0);
          3'd4:    p = mk(1'b0, 3, 0, 4, 0);
          default: p = mk(1'b1, 0, 1, 2, 3);
        endcase
      end
      SH_PRISM: begin
        case (k)
          3'd1:    p = mk(1'b1, 2, 1, 4, 5);
          3'd2:    p = mk(1'b1, 1, 0, 3, 4);
          3'd3:    p = mk(1'b0, 0, 1, 2, 0);
          3'd4:    p = mk(1'b0, 3, 4, 5, 0);
          default: p = mk(1'b1, 0, 2, 5, 3);
        endcase
      end
      SH_HEX: begin
        case (k)
          3'd1:    p = mk(1'b1, 0, 1, 5, 4);
          3'd2:    p = mk(1'b1, 1, 2, 6, 5);
          3'd3:    p = mk(1'b1, 2, 3, 7, 6);
          3'd4:    p = mk(1'b1, 3, 0, 4, 7);
          3'd5:    p = mk(1'b1, 4, 5, 6, 7);
          default: p = mk(1'b1, 0, 1, 2, 3);
        endcase
      end
      default: p = mk(1'b0, 0, 1, 2, 0);
    endcase
    return p;
  endfunction

endpackage

@@ rtl/fpm_ram.sv @@
module fpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fpm_face_sel.sv @@
module fpm_face_sel import fpm_pkg::*; (
  input  cell_in_t   item,
  input  logic [2:0] k,
  output face_t      face
);

  shape_t                sh;
  pick_t                 pk;
  logic [VTX_W-1:0]      vv [8];
  logic [VTX_W-1:0]      a0, a1, a2, a3, b0, b1, b2, b3, c1, c2;

  assign vv[0] = item.vertex_0;
  assign vv[1] = item.vertex_1;
  assign vv[2] = item.vertex_2;
  assign vv[3] = item.vertex_3;
  assign vv[4] = item.vertex_4;
  assign vv[5] = item.vertex_5;
  assign vv[6] = item.vertex_6;
  assign vv[7] = item.vertex_7;

  always_comb begin
    sh = SH_BAD;
    if (item.boundary) begin
      case (item.vertex_count)
        4'd3:    sh = SH_BTRI;
        4'd4:    sh = SH_BQUAD;
        default: sh = SH_BAD;
      endcase
    end else begin
      case (item.vertex_count)
        4'd4:    sh = SH_TET;
        4'd5:    sh = SH_PYR;
        4'd6:    sh = SH_PRISM;
        4'd8:    sh = SH_HEX;
        default: sh = SH_BAD;
      endcase
    end
  end

  assign pk = face_pick(sh, k);

  // a triangle gets an all-ones fourth id so it sorts to the top
  always_comb begin
    a0 = vv[pk.i0];
    a1 = vv[pk.i1];
    a2 = vv[pk.i2];
    a3 = pk.quad ? vv[pk.i3] : '1;
    b0 = (a0 < a1) ? a0 : a1;
    b1 = (a0 < a1) ? a1 : a0;
    b2 = (a2 < a3) ? a2 : a3;
    b3 = (a2 < a3) ? a3 : a2;
    face.key[0] = (b0 < b2) ? b0 : b2;
    c2          = (b0 < b2) ? b2 : b0;
    c1          = (b1 < b3) ? b1 : b3;
    face.key[3] = (b1 < b3) ? b3 : b1;
    face.key[1] = (c1 < c2) ? c1 : c2;
    face.key[2] = (c1 < c2) ? c2 : c1;
    face.bad     = (sh == SH_BAD);
    face.is_quad = pk.quad;
    face.last    = (k == face_count(sh) - 3'd1);
  end

endmodule

@@ rtl/fpm_probe.sv @@
module fpm_probe import fpm_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CNT_W-1:0]  tri_total,
  input  probe_ctl_t        ctl,
  input  req_t              req,
  output probe_stat_t       stat,
  output res_t              res
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int TRI_W  = 2 + CELL_W + 3 * VTX_W;
  localparam int QUAD_W = 2 + CELL_W + 4 * VTX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_RD, S_CHK, S_RES} state_t;

  state_t             state;
  req_t               cur;
  logic [IDX_W-1:0]   clr_addr, p, p_inc, probes, free_idx, waddr, raddr;
  logic               have_free;
  logic [CNT_W-1:0]   tri_cnt, quad_cnt;
  logic [TRI_W-1:0]   t_rdata, t_wdata;
  logic [QUAD_W-1:0]  q_rdata, q_wdata;
  logic               t_we, q_we, we;
  logic [1:0]         e_state, w_state;
  logic [CELL_W-1:0]  e_cell;
  logic [3:0][VTX_W-1:0] e_key;
  logic               hit, stop, can_put;
  logic [IDX_W-1:0]   put_idx;

  function automatic logic [IDX_W-1:0] hash(logic [3:0][VTX_W-1:0] k);
    logic [VTX_W-1:0] t;
    logic [IDX_W-1:0] h;
    t = k[0] ^ {k[1][16:0], k[1][23:17]} ^ {k[2][10:0], k[2][23:11]}
        ^ {k[3][4:0], k[3][23:5]};
    h = '0;
    for (int i = 0; i < VTX_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ t[i];
    end
    if ({1'b0, h} >= (IDX_W+1)'(TABLE_DEPTH)) begin
      h = h - IDX_W'(TABLE_DEPTH);
    end
    return h;
  endfunction

  assign p_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  assign raddr = (state == S_CHK) ? p_inc : p;

  always_comb begin
    if (cur.is_quad) begin
      e_state = q_rdata[QUAD_W-1 -: 2];
      e_cell  = q_rdata[4*VTX_W +: CELL_W];
      e_key   = q_rdata[4*VTX_W-1:0];
    end else begin
      e_state = t_rdata[TRI_W-1 -: 2];
      e_cell  = t_rdata[3*VTX_W +: CELL_W];
      e_key   = {{VTX_W{1'b1}}, t_rdata[3*VTX_W-1:0]};
    end
    hit = (e_state == E_USED) && (e_key[0] == cur.key[0]) && (e_key[1] == cur.key[1])
          && (e_key[2] == cur.key[2]) && (!cur.is_quad || (e_key[3] == cur.key[3]));
    stop    = hit || (e_state == E_EMPTY) || (probes == LAST_IDX);
    can_put = have_free || (e_state != E_USED);
    put_idx = have_free ? free_idx : p;
  end

  always_comb begin
    we      = 1'b0;
    waddr   = clr_addr;
    w_state = E_EMPTY;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (state == S_CHK && hit) begin
      we      = 1'b1;
      waddr   = p;
      w_state = E_TOMB;
    end else if (state == S_CHK && stop && can_put) begin
      we      = 1'b1;
      waddr   = put_idx;
      w_state = E_USED;
    end
    t_we    = we && ((state == S_CLEAR) || !cur.is_quad);
    q_we    = we && ((state == S_CLEAR) || cur.is_quad);
    t_wdata = (state == S_CLEAR) ? '0 : {w_state, cur.cell_id, cur.key[2:0]};
    q_wdata = (state == S_CLEAR) ? '0 : {w_state, cur.cell_id, cur.key};
  end

  fpm_ram #(.WIDTH(TRI_W), .DEPTH(TABLE_DEPTH)) u_tri_ram (
    .clk(clk), .we(t_we), .waddr(waddr), .wdata(t_wdata), .raddr(raddr), .rdata(t_rdata)
  );

  fpm_ram #(.WIDTH(QUAD_W), .DEPTH(TABLE_DEPTH)) u_quad_ram (
    .clk(clk), .we(q_we), .waddr(waddr), .wdata(q_wdata), .raddr(raddr), .rdata(q_rdata)
  );

  assign stat.clearing  = (state == S_CLEAR);
  assign stat.req_take  = (state == S_IDLE) && ctl.req_valid;
  assign stat.res_valid = (state == S_RES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      tri_cnt  <= '0;
      quad_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (ctl.req_valid) begin
            cur   <= req;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          p         <= hash(cur.key);
          probes    <= '0;
          have_free <= 1'b0;
          state     <= S_RD;
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (hit) begin
            res.status   <= ST_MATCH;
            res.cell_old <= e_cell;
            if (cur.is_quad) begin
              res.slot <= SLOT_W'(tri_total) + SLOT_W'(quad_cnt);
              quad_cnt <= quad_cnt + 1'b1;
            end else begin
              res.slot <= SLOT_W'(tri_cnt);
              tri_cnt  <= tri_cnt + 1'b1;
            end
            state <= S_RES;
          end else if (stop) begin
            res.status   <= can_put ? ST_INSERT : ST_FULL;
            res.cell_old <= '0;
            res.slot     <= '0;
            state        <= S_RES;
          end else begin
            // remember the first reusable slot, keep walking
            if (e_state == E_TOMB && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= p;
            end
            p      <= p_inc;
            probes <= probes + 1'b1;
          end
        end
        S_RES: begin
          if (ctl.res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/mesh_face_pair_matcher.sv @@
// Channel  | Signals                               | Moves
// ---------+---------------------------------------+-------------------------------
// cell     | cell_valid, cell_stall, cell_data     | one mesh cell per transaction
// face     | face_valid, face_stall, face          | one face result per transaction
// config   | tri_total_we, tri_total_wdata         | first quad slot, write only
//
// After reset a clearing pass marks every table entry empty, holding cell_stall high.
// Each face walks its hash chain in the tri or quad table memory, one probe per cycle
// through the read port; a cell takes up to six faces in turn. A bad vertex count gives
// its one result from the load state once the output is free, without a table lookup.
// Reset is synchronous and active high. A stalled face result holds the engine; the
// next cell is taken once the last face of the current one has been registered for
// output.
module mesh_face_pair_matcher import fpm_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tri_total_we,
  input  logic [CNT_W-1:0]  tri_total_wdata,
  input  logic              cell_valid,
  output logic              cell_stall,
  input  cell_in_t          cell_data,
  output logic              face_valid,
  input  logic              face_stall,
  output face_out_t         face
);

  typedef enum logic [1:0] {T_IDLE, T_LOAD, T_ISSUE, T_WAIT} tstate_t;

  tstate_t      tstate;
  cell_in_t     item;
  logic [2:0]   k;
  logic         last_face;
  logic [CNT_W-1:0] tri_total;
  face_t        sel;
  req_t         req;
  res_t         res;
  probe_ctl_t   ctl;
  probe_stat_t  stat;
  logic         out_free;
  logic         face_load;

  assign out_free      = !face_valid || !face_stall;
  assign cell_stall    = (tstate != T_IDLE) || stat.clearing;
  assign ctl.req_valid = (tstate == T_ISSUE);
  assign ctl.res_take  = (tstate == T_WAIT) && stat.res_valid && out_free;
  assign face_load     = out_free && (((tstate == T_LOAD) && sel.bad)
                                      || ((tstate == T_WAIT) && stat.res_valid));

  // split the held cell into its k-th face with a sorted key
  fpm_face_sel u_face_sel (
    .item(item),
    .k(k),
    .face(sel)
  );

  // hash table search, insert and remove
  fpm_probe #(.TABLE_DEPTH(TABLE_DEPTH)) u_probe (
    .clk(clk),
    .rst(rst),
    .tri_total(tri_total),
    .ctl(ctl),
    .req(req),
    .stat(stat),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate     <= T_IDLE;
      face_valid <= 1'b0;
      tri_total  <= '0;
    end else begin
      if (tri_total_we) begin
        tri_total <= tri_total_wdata;
      end
      // raise on a new result, drop the output once taken
      if (face_load) begin
        face_valid <= 1'b1;
      end else if (!face_stall) begin
        face_valid <= 1'b0;
      end
      case (tstate)
        T_IDLE: begin
          if (cell_valid && !cell_stall) begin
            item   <= cell_data;
            k      <= '0;
            tstate <= T_LOAD;
          end
        end
        T_LOAD: begin
          if (sel.bad) begin
            // bad vertex count: one result straight out, table untouched
            if (out_free) begin
              face.status    <= ST_BAD;
              face.is_quad   <= 1'b0;
              face.face_slot <= '0;
              face.cell_new  <= item.cell_id;
              face.cell_old  <= '0;
              face.last      <= 1'b1;
              tstate         <= T_IDLE;
            end
          end else begin
            req.is_quad <= sel.is_quad;
            req.cell_id <= item.cell_id;
            req.key     <= sel.key;
            last_face   <= sel.last;
            tstate      <= T_ISSUE;
          end
        end
        T_ISSUE: begin
          if (stat.req_take) begin
            tstate <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (stat.res_valid && out_free) begin
            face.status    <= res.status;
            face.is_quad   <= req.is_quad;
            face.face_slot <= res.slot;
            face.cell_new  <= item.cell_id;
            face.cell_old  <= res.cell_old;
            face.last      <= last_face;
            if (last_face) begin
              tstate <= T_IDLE;
            end else begin
              k      <= k + 3'd1;
              tstate <= T_LOAD;
            end
          end
        end
        default: tstate <= T_IDLE;
      endcase
    end
  end

endmodule
